FILE: rtl/core/plist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LENGTH = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LENGTH,
    OP_ERROR,
    OP_LOAD_INS,
    OP_LOAD_REM,
    OP_READ_POS,
    OP_READ_HEAD,
    OP_SHIFT_UP,
    OP_SHIFT_DN,
    OP_WRITE_VAL,
    OP_DEC_CNT,
    OP_EMIT_ENTRY
  } dp_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHUP,
    S_SHDN,
    S_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t err_code;
  } plist_cmd_t;

  typedef struct packed {
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic full;
    logic empty;
    logic busy;
    logic can_emit;
    logic emit_last;
  } plist_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/plist_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plist_ctrl
// Command sequencer: decodes each request and steps the datapath through
// shifting, writing and result emission.
// ----------------------------------------------------------------------------
module plist_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [2:0]              in_command,
  input  wire plist_pkg::plist_stat_t  stat,
  output plist_pkg::plist_cmd_t        cmd
);
  import plist_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = !((state_r == S_IDLE) && stat.can_emit);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_command))
            CMD_INSERT: if (!stat.pos_gt_cnt && !stat.full) state_nxt = S_SHUP;
            CMD_QUERY:  if (!stat.pos_ge_cnt) state_nxt = S_EMIT;
            CMD_REMOVE: if (!stat.pos_ge_cnt) state_nxt = S_SHDN;
            CMD_DUMP:   if (!stat.empty) state_nxt = S_EMIT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SHUP: if (!stat.busy) state_nxt = S_IDLE;
      S_SHDN: if (!stat.busy) state_nxt = S_IDLE;
      S_EMIT: if (stat.can_emit && stat.emit_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.err_code = ST_RANGE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_command))
            CMD_LENGTH: cmd.op = OP_LENGTH;
            CMD_INSERT: begin
              if (stat.pos_gt_cnt) begin
                cmd.op = OP_ERROR;
              end else if (stat.full) begin
                cmd.op       = OP_ERROR;
                cmd.err_code = ST_FULL;
              end else begin
                cmd.op = OP_LOAD_INS;
              end
            end
            CMD_QUERY:  cmd.op = stat.pos_ge_cnt ? OP_ERROR : OP_READ_POS;
            CMD_REMOVE: cmd.op = stat.pos_ge_cnt ? OP_ERROR : OP_LOAD_REM;
            CMD_DUMP: begin
              if (stat.empty) begin
                cmd.op       = OP_ERROR;
                cmd.err_code = ST_EMPTY;
              end else begin
                cmd.op = OP_READ_HEAD;
              end
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      S_SHUP: cmd.op = stat.busy ? OP_SHIFT_UP : OP_WRITE_VAL;
      S_SHDN: cmd.op = stat.busy ? OP_SHIFT_DN : OP_DEC_CNT;
      S_EMIT: if (stat.can_emit) cmd.op = OP_EMIT_ENTRY;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/plist_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plist_dp
// Entry memory, count, shift pointers and the result output register.
// ----------------------------------------------------------------------------
module plist_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic [plist_pkg::POS_W-1:0]             in_position,
  input  wire logic signed [plist_pkg::DATA_W-1:0]     in_item_value,
  input  wire plist_pkg::plist_cmd_t                   cmd,
  output plist_pkg::plist_stat_t                       stat,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [plist_pkg::DATA_W-1:0]          out_result_value,
  output logic [1:0]                                   out_status,
  output logic                                         out_last
);
  import plist_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic              pend_r, pend_nxt;
  logic              rd_more_r, rd_more_nxt;
  logic              single_r, single_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data;
  logic [POS_W-1:0]  cnt_ext, pos_plus1;
  logic [CW-1:0]     cnt_m1;
  logic              emit_last;

  assign cnt_ext   = POS_W'(cnt_r);
  assign cnt_m1    = cnt_r - CW'(1);
  assign pos_plus1 = in_position + POS_W'(1);
  assign emit_last = single_r || (CW'(idx_r) == cnt_m1);

  assign stat.pos_gt_cnt = in_position > cnt_ext;
  assign stat.pos_ge_cnt = in_position >= cnt_ext;
  assign stat.full       = cnt_r == CW'(CAPACITY);
  assign stat.empty      = cnt_r == '0;
  assign stat.busy       = rd_more_r || pend_r;
  assign stat.can_emit   = !out_valid_r || !out_stall;
  assign stat.emit_last  = emit_last;

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    pend_addr_nxt  = pend_addr_r;
    pend_nxt       = pend_r;
    rd_more_nxt    = rd_more_r;
    single_nxt     = single_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = pend_addr_r;
    rd_addr        = idx_r;
    wr_data        = rd_data_r;
    case (cmd.op)
      OP_LENGTH: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = DATA_W'(cnt_r);
        out_status_nxt = ST_OK;
        out_last_nxt   = 1'b1;
      end
      OP_ERROR: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = '1;
        out_status_nxt = cmd.err_code;
        out_last_nxt   = 1'b1;
      end
      OP_LOAD_INS: begin
        pos_nxt     = in_position[AW-1:0];
        val_nxt     = in_item_value;
        idx_nxt     = cnt_m1[AW-1:0];
        rd_more_nxt = in_position < cnt_ext;
        pend_nxt    = 1'b0;
      end
      OP_LOAD_REM: begin
        idx_nxt     = pos_plus1[AW-1:0];
        rd_more_nxt = pos_plus1 < cnt_ext;
        pend_nxt    = 1'b0;
      end
      OP_READ_POS: begin
        rd_en      = 1'b1;
        rd_addr    = in_position[AW-1:0];
        idx_nxt    = in_position[AW-1:0];
        single_nxt = 1'b1;
      end
      OP_READ_HEAD: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        idx_nxt    = '0;
        single_nxt = 1'b0;
      end
      // read walks down from the tail, each entry written one slot higher
      OP_SHIFT_UP: begin
        wr_en         = pend_r;
        wr_addr       = pend_addr_r + AW'(1);
        rd_en         = rd_more_r;
        pend_nxt      = rd_more_r;
        pend_addr_nxt = idx_r;
        idx_nxt       = idx_r - AW'(1);
        rd_more_nxt   = rd_more_r && (idx_r != pos_r);
      end
      // read walks up toward the tail, each entry written one slot lower
      OP_SHIFT_DN: begin
        wr_en         = pend_r;
        wr_addr       = pend_addr_r - AW'(1);
        rd_en         = rd_more_r;
        pend_nxt      = rd_more_r;
        pend_addr_nxt = idx_r;
        idx_nxt       = idx_r + AW'(1);
        rd_more_nxt   = rd_more_r && (CW'(idx_r) != cnt_m1);
      end
      OP_WRITE_VAL: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = val_r;
        cnt_nxt = cnt_r + CW'(1);
      end
      OP_DEC_CNT: begin
        cnt_nxt = cnt_m1;
      end
      // emit current entry and prefetch the next one
      OP_EMIT_ENTRY: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = rd_data_r;
        out_status_nxt = ST_OK;
        out_last_nxt   = emit_last;
        if (!emit_last) begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      rd_more_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      rd_more_r   <= rd_more_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    pend_addr_r  <= pend_addr_nxt;
    single_r     <= single_nxt;
    val_r        <= val_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/positional_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values in a bounded store.
// ----------------------------------------------------------------------------
// One request is taken at a time. Length and every error answer go straight to
// the output register; query reads the entry and emits it; dump emits the
// entries head first, waiting out any output stall. Insert shifts entries
// p and up one slot higher, then writes; remove shifts the entries above p
// down one slot. Insert and remove time is set by the entry memory,
// which moves one entry per cycle through its one read and one write port.
// A new request is taken only while the output register is free or draining.
// There is no clearing pass after reset: the count starts at zero.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [plist_pkg::CMD_W-1:0]         in_command,
  input  wire logic [plist_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [plist_pkg::DATA_W-1:0] in_item_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [plist_pkg::DATA_W-1:0]      out_result_value,
  output logic [1:0]                               out_status,
  output logic                                     out_last
);
  import plist_pkg::*;

  plist_cmd_t  cmd;
  plist_stat_t stat;

  plist_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  plist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

FILE: tb/list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// Watches both channels of the positional list engine, keeps a mirror of the
// list, works out the answers of every accepted request and compares them
// field by field with the answers that come out, oldest first.
// ----------------------------------------------------------------------------
module list_checker #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [plist_pkg::CMD_W-1:0]         in_command,
  input  logic [plist_pkg::POS_W-1:0]         in_position,
  input  logic signed [plist_pkg::DATA_W-1:0] in_item_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [plist_pkg::DATA_W-1:0] out_result_value,
  input  logic [1:0]                          out_status,
  input  logic                                out_last,
  output int                                  fail_count,
  output int                                  pending
);
  import plist_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     last;
  } answer_t;

  localparam logic signed [DATA_W-1:0] NO_ENTRY = -1;

  answer_t                  expected_answers[$];
  logic signed [DATA_W-1:0] mirror_entries[LIST_DEPTH];
  int                       mirror_len;

  task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                    input logic [POS_W-1:0] pos,
                                    input logic signed [DATA_W-1:0] val);
    int p;
    int j;
    p = int'(pos);
    case (cmd)
      CMD_LENGTH: begin
        expected_answers.push_back(answer_t'{mirror_len, ST_OK, 1'b1});
      end
      CMD_INSERT: begin
        // range check wins over the full check
        if (p > mirror_len) begin
          expected_answers.push_back(answer_t'{NO_ENTRY, ST_RANGE, 1'b1});
        end else if (mirror_len >= LIST_DEPTH) begin
          expected_answers.push_back(answer_t'{NO_ENTRY, ST_FULL, 1'b1});
        end else begin
          for (j = mirror_len; j > p; j--) mirror_entries[j] = mirror_entries[j-1];
          mirror_entries[p] = val;
          mirror_len++;
        end
      end
      CMD_QUERY: begin
        if (p >= mirror_len) begin
          expected_answers.push_back(answer_t'{NO_ENTRY, ST_RANGE, 1'b1});
        end else begin
          expected_answers.push_back(answer_t'{mirror_entries[p], ST_OK, 1'b1});
        end
      end
      CMD_REMOVE: begin
        if (p >= mirror_len) begin
          expected_answers.push_back(answer_t'{NO_ENTRY, ST_RANGE, 1'b1});
        end else begin
          for (j = p; j + 1 < mirror_len; j++) mirror_entries[j] = mirror_entries[j+1];
          mirror_len--;
        end
      end
      CMD_DUMP: begin
        if (mirror_len == 0) begin
          expected_answers.push_back(answer_t'{NO_ENTRY, ST_EMPTY, 1'b1});
        end else begin
          for (j = 0; j < mirror_len; j++) begin
            expected_answers.push_back(answer_t'{mirror_entries[j], ST_OK,
                                                 (j + 1 == mirror_len)});
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    answer_t want;
    logic    bad;
    if (!rst_n) begin
      expected_answers.delete();
      mirror_len = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      bad = 1'b0;
      // results first, so an answer never meets an expectation of the same edge
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $display("%0t unexpected result: expected none, actual value %0d status %0d last %0d",
                   $time, out_result_value, out_status, out_last);
          bad = 1'b1;
        end else begin
          want = expected_answers.pop_front();
          if (out_result_value !== want.value) begin
            $display("%0t result_value mismatch: expected %0d, actual %0d",
                     $time, want.value, out_result_value);
            bad = 1'b1;
          end
          if (out_status !== want.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            bad = 1'b1;
          end
          if (out_last !== want.last) begin
            $display("%0t last mismatch: expected %0d, actual %0d",
                     $time, want.last, out_last);
            bad = 1'b1;
          end
        end
      end
      if (in_valid && !in_stall) apply_list_command(in_command, in_position, in_item_value);
      if (bad) fail_count <= fail_count + 1;
      pending <= expected_answers.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the positional list engine with a directed opening, a fill to
// capacity and random request mixes under varying idle and stall pressure;
// a separate checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module testbench;
  import plist_pkg::*;

  localparam int     LIST_DEPTH   = 64;
  localparam int     CMD_CODES    = 1 << CMD_W;
  localparam int     POS_MAX      = (1 << POS_W) - 1;
  localparam int     PHASE_ITEMS  = 58;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     TAIL_CYCLES  = 200;
  localparam longint TIMEOUT_NS   = 15_000_000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic [CMD_W-1:0]         in_command = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic                     out_stall = 1'b0;
  wire                      in_stall;
  wire                      out_valid;
  wire signed [DATA_W-1:0]  out_result_value;
  wire [1:0]                out_status;
  wire                      out_last;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int list_len = 0;
  int random_issued = 0;

  always #5 clk = ~clk;

  positional_list_engine #(.CAPACITY(LIST_DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  list_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // mostly a live entry, sometimes a position past the end
  function automatic logic [POS_W-1:0] pick_entry_pos();
    if (list_len == 0 || $urandom_range(7) == 0) return POS_W'($urandom_range(POS_MAX, list_len));
    return POS_W'($urandom_range(list_len - 1));
  endfunction

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                       input logic [DATA_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    in_item_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    // track the length so positions can be aimed inside the list
    case (cmd)
      CMD_INSERT: if (int'(pos) <= list_len && list_len < LIST_DEPTH) list_len++;
      CMD_REMOVE: if (int'(pos) < list_len) list_len--;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_request();
    int ins_w;
    int r;
    ins_w = (list_len < 6) ? 60 : (list_len > 48) ? 20 : 40;
    r = $urandom_range(99);
    if (r < ins_w) begin
      if ($urandom_range(19) == 0) begin
        issue(CMD_INSERT, POS_W'($urandom_range(POS_MAX, list_len + 1)), pick_value());
      end else begin
        issue(CMD_INSERT, POS_W'($urandom_range(list_len)), pick_value());
      end
      random_issued++;
    end else begin
      r = $urandom_range(99);
      if (r < 40) begin
        issue(CMD_REMOVE, pick_entry_pos(), pick_value());
      end else if (r < 75) begin
        issue(CMD_QUERY, pick_entry_pos(), pick_value());
      end else if (r < 85) begin
        issue(CMD_LENGTH, POS_W'($urandom()), pick_value());
      end else if (r < 93) begin
        issue(CMD_DUMP, POS_W'($urandom()), pick_value());
      end else begin
        // spare codes are dropped by the block and not counted
        issue(CMD_W'($urandom_range(CMD_CODES - 1, int'(CMD_DUMP) + 1)),
              POS_W'($urandom()), pick_value());
        random_issued--;
      end
      random_issued++;
    end
  endtask

  initial begin
    int c;
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corner cases
    issue(CMD_LENGTH, 0, 0);
    issue(CMD_QUERY, 0, 0);
    issue(CMD_REMOVE, 0, 0);
    issue(CMD_DUMP, 0, 0);
    issue(CMD_INSERT, 1, 32'h1234_5678);
    // head, tail and middle inserts with extreme values
    issue(CMD_INSERT, 0, 32'h7fff_ffff);
    issue(CMD_INSERT, 0, 32'h8000_0000);
    issue(CMD_INSERT, 2, '1);
    issue(CMD_INSERT, 1, '0);
    issue(CMD_INSERT, POS_W'(POS_MAX), 32'h5555_aaaa);
    issue(CMD_QUERY, 0, 0);
    issue(CMD_QUERY, 3, 0);
    issue(CMD_QUERY, 4, 0);
    issue(CMD_QUERY, POS_W'(POS_MAX), '1);
    issue(CMD_DUMP, 0, 0);
    issue(CMD_REMOVE, 4, 0);
    issue(CMD_REMOVE, 1, 0);
    issue(CMD_REMOVE, 2, 0);
    issue(CMD_REMOVE, 0, 0);
    issue(CMD_LENGTH, 0, 0);
    for (c = int'(CMD_DUMP) + 1; c < CMD_CODES; c++) issue(CMD_W'(c), POS_W'(POS_MAX), '1);
    issue(CMD_DUMP, 0, 0);

    // fill to capacity with the receiver mostly stalled
    recv_stall_pct = 85;
    while (list_len < LIST_DEPTH) issue(CMD_INSERT, POS_W'($urandom_range(list_len)), pick_value());
    issue(CMD_INSERT, POS_W'(list_len), pick_value());
    issue(CMD_INSERT, 0, pick_value());
    issue(CMD_INSERT, POS_W'(list_len + 1), pick_value());
    issue(CMD_INSERT, POS_W'(POS_MAX), pick_value());
    issue(CMD_QUERY, POS_W'(list_len - 1), 0);
    issue(CMD_QUERY, POS_W'(list_len), 0);
    issue(CMD_DUMP, 0, 0);
    issue(CMD_LENGTH, 0, 0);

    // shrink back with the sender mostly idle
    recv_stall_pct = 0;
    send_idle_pct = 85;
    while (list_len > 8) issue(CMD_REMOVE, POS_W'($urandom_range(list_len - 1)), pick_value());

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_requests++;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      while (random_issued < phase * PHASE_ITEMS + PHASE_ITEMS / 2) random_request();
      if (phase >= 2) wait_drained();
      while (random_issued < (phase + 1) * PHASE_ITEMS) random_request();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("positional_list_engine regression: fail");
    $finish;
  end

endmodule
